/* sv/pet_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pet_pkg
// Shared types and constants of the periodic event table timer.
// ----------------------------------------------------------------------------
package pet_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int OP_W      = 2;
  localparam int ELAPSED_W = 16;
  localparam int TIME_W    = 40;
  localparam int PERIOD_W  = 32;
  localparam int LIMIT_W   = 16;
  localparam int TAG_W     = 8;
  localparam int POS_W     = 32;

  localparam int IN_DATA_W  = 176;
  localparam int OUT_DATA_W = 72;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  localparam logic [TIME_W-1:0] CLOCK_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [TIME_W-1:0]   start;
    logic [PERIOD_W-1:0] period;
    logic [LIMIT_W-1:0]  limit;
    logic [LIMIT_W-1:0]  fired;
    logic [TIME_W-1:0]   last_fire;
    logic                ended;
    logic [TAG_W-1:0]    tag;
    logic [POS_W-1:0]    x;
    logic [POS_W-1:0]    y;
  } entry_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } event_t;

  typedef struct packed {
    logic              sub;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] res;
    logic              carry;
  } alu_rsp_t;

endpackage

/* sv/pet_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pet_alu
// Shared 40-bit add/subtract unit; carry out doubles as "no borrow".
// ----------------------------------------------------------------------------
module pet_alu (
  input  pet_pkg::alu_req_t req,
  output pet_pkg::alu_rsp_t rsp
);

  logic [pet_pkg::TIME_W-1:0] b_eff;
  logic [pet_pkg::TIME_W:0]   sum;

  always_comb begin
    b_eff   = req.sub ? ~req.b : req.b;
    sum     = {1'b0, req.a} + {1'b0, b_eff} + {{pet_pkg::TIME_W{1'b0}}, req.sub};
    rsp.res   = sum[pet_pkg::TIME_W-1:0];
    rsp.carry = sum[pet_pkg::TIME_W];
  end

endmodule

/* sv/pet_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pet_table
// Entry memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pet_table (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [pet_pkg::IDX_W-1:0]   wr_addr,
  input  pet_pkg::entry_t             wr_data,
  input  logic                        rd_en,
  input  logic [pet_pkg::IDX_W-1:0]   rd_addr,
  output pet_pkg::entry_t             rd_data_r
);

  pet_pkg::entry_t mem_r [pet_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

endmodule

/* sv/periodic_event_table_timer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_event_table_timer_top
// Table of periodic event generators driven by a saturating tick clock.
// ----------------------------------------------------------------------------
// Usage: the in_ stream carries commands (in_tuser selects clear, add or
// tick); the out_ stream carries one word per firing, in table order, with
// out_tlast set on the final event of a tick.
// A tick runs a clock update, then visits entries in table order: memory
// read, start compare, age subtract, period compare and write-back per
// entry, though not every entry needs every step; it ends with a flush of
// the held event. The single shared 40-bit add/subtract unit and the
// registered read port of the entry memory make these steps sequential.
// in_tready is high only while no command is in progress.
// Each event is held one step so that tlast can be set on the final one;
// when the receiver stalls the walk waits at the next firing or at the end.
// Reset zeroes the clock and empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
module periodic_event_table_timer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // elapsed, start_time, period, repeat_limit, type_tag, pos_x, pos_y
  input  logic [pet_pkg::IN_DATA_W-1:0]   in_tdata,
  // op
  input  logic [pet_pkg::OP_W-1:0]        in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tag, out_pos_x, out_pos_y
  output logic [pet_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tlast
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLK   = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_AHEAD = 3'd3;
  localparam logic [2:0] ST_DIFF  = 3'd4;
  localparam logic [2:0] ST_PER   = 3'd5;
  localparam logic [2:0] ST_FIRE  = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]                       state_r, state_nxt;
  logic [pet_pkg::TIME_W-1:0]       clock_r, clock_nxt;
  logic [pet_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic [pet_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic [pet_pkg::ELAPSED_W-1:0]    elapsed_r, elapsed_nxt;
  logic [pet_pkg::TIME_W-1:0]       diff_r, diff_nxt;
  logic                             pend_valid_r, pend_valid_nxt;
  pet_pkg::event_t                  pend_r, pend_nxt;
  logic                             out_valid_r, out_valid_nxt;
  pet_pkg::event_t                  out_r, out_nxt;
  logic                             out_last_r, out_last_nxt;

  pet_pkg::alu_req_t                alu_req;
  pet_pkg::alu_rsp_t                alu_rsp;

  logic                             wr_en;
  logic [pet_pkg::IDX_W-1:0]        wr_addr;
  pet_pkg::entry_t                  wr_data;
  logic                             rd_en;
  pet_pkg::entry_t                  rd_data;

  logic                             out_free;
  logic                             at_end;
  logic [pet_pkg::LIMIT_W-1:0]      fired_inc;
  logic [pet_pkg::LIMIT_W-1:0]      lim_eff;

  pet_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  pet_table u_table (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (idx_r),
    .rd_data_r (rd_data)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.y, out_r.x, out_r.tag};
  assign out_tlast  = out_last_r;

  assign out_free  = !out_valid_r || out_tready;
  assign at_end    = (({1'b0, idx_r} + 1'b1) >= count_r);
  assign fired_inc = rd_data.fired + 1'b1;
  assign lim_eff   = (rd_data.limit == '0) ? {{(pet_pkg::LIMIT_W-1){1'b0}}, 1'b1}
                                           : rd_data.limit;

  always_comb begin
    state_nxt      = state_r;
    clock_nxt      = clock_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    elapsed_nxt    = elapsed_r;
    diff_nxt       = diff_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;
    alu_req        = '0;
    wr_en          = 1'b0;
    wr_addr        = count_r[pet_pkg::IDX_W-1:0];
    wr_data        = rd_data;
    rd_en          = 1'b0;

    // drop the word once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            pet_pkg::OP_CLEAR: begin
              clock_nxt = '0;
              count_nxt = '0;
            end
            pet_pkg::OP_ADD: begin
              if (count_r < pet_pkg::CNT_W'(pet_pkg::TABLE_DEPTH)) begin
                wr_en             = 1'b1;
                wr_data.start     = in_tdata[55:16];
                wr_data.period    = in_tdata[87:56];
                wr_data.limit     = in_tdata[103:88];
                wr_data.tag       = in_tdata[111:104];
                wr_data.x         = in_tdata[143:112];
                wr_data.y         = in_tdata[175:144];
                wr_data.fired     = '0;
                wr_data.last_fire = '0;
                wr_data.ended     = 1'b0;
                count_nxt         = count_r + 1'b1;
              end
            end
            pet_pkg::OP_TICK: begin
              elapsed_nxt = in_tdata[15:0];
              state_nxt   = ST_CLK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLK: begin
        alu_req.sub = 1'b0;
        alu_req.a   = clock_r;
        alu_req.b   = {{(pet_pkg::TIME_W-pet_pkg::ELAPSED_W){1'b0}}, elapsed_r};
        clock_nxt   = alu_rsp.carry ? pet_pkg::CLOCK_MAX : alu_rsp.res;
        idx_nxt     = '0;
        state_nxt   = (count_r == '0) ? ST_FIN : ST_RD;
      end
      ST_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_AHEAD;
      end
      ST_AHEAD: begin
        alu_req.sub = 1'b1;
        alu_req.a   = clock_r;
        alu_req.b   = rd_data.start;
        if (rd_data.ended) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = at_end ? ST_FIN : ST_RD;
        end else if (!alu_rsp.carry) begin
          state_nxt = ST_FIN;
        end else if (rd_data.fired == '0) begin
          state_nxt = ST_FIRE;
        end else begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        alu_req.sub = 1'b1;
        alu_req.a   = clock_r;
        alu_req.b   = rd_data.last_fire;
        diff_nxt    = alu_rsp.res;
        state_nxt   = ST_PER;
      end
      ST_PER: begin
        alu_req.sub = 1'b1;
        alu_req.a   = diff_r;
        alu_req.b   = {{(pet_pkg::TIME_W-pet_pkg::PERIOD_W){1'b0}}, rd_data.period};
        if (alu_rsp.carry) begin
          state_nxt = ST_FIRE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = at_end ? ST_FIN : ST_RD;
        end
      end
      ST_FIRE: begin
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = pend_r;
            out_last_nxt  = 1'b0;
          end
          pend_valid_nxt    = 1'b1;
          pend_nxt.tag      = rd_data.tag;
          pend_nxt.x        = rd_data.x;
          pend_nxt.y        = rd_data.y;
          wr_en             = 1'b1;
          wr_addr           = idx_r;
          wr_data.fired     = fired_inc;
          wr_data.ended     = (fired_inc >= lim_eff);
          wr_data.last_fire = clock_r;
          idx_nxt           = idx_r + 1'b1;
          state_nxt         = at_end ? ST_FIN : ST_RD;
        end
      end
      ST_FIN: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_nxt        = pend_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      clock_r      <= '0;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clock_r      <= clock_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    elapsed_r  <= elapsed_nxt;
    diff_r     <= diff_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
